// ===== hw/rtl/fffs_pkg.sv =====
`default_nettype none
// Package for the fair FIFO counting semaphore.
// Holds widths, queue sizing, operation and outcome codes, and the structs
// that pass between the sequencer, the waiter queue and the shared adder.
package fffs_pkg;

   localparam int ID_W        = 8;
   localparam int CNT_W       = 16;
   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;

   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QSUM_W  = QFILL_W + 1;
   localparam int GRANT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(1);

   typedef enum logic [1:0] {
      FN_TRY    = 2'd0,
      FN_ACQ    = 2'd1,
      FN_REL    = 2'd2,
      FN_CANCEL = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      OUT_ACQUIRED = 3'd0,
      OUT_QUEUED   = 3'd1,
      OUT_BUSY     = 3'd2,
      OUT_FULL     = 3'd3,
      OUT_GRANTED  = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACQ,
      ST_ADD,
      ST_WALK,
      ST_FLUSH,
      ST_CANCEL
   } state_type;

   typedef enum logic {
      ALU_SUB,
      ALU_ADD_SAT
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [CNT_W-1:0] a;
      logic [CNT_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] value;
      logic             borrow;
   } alu_res_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic               head_clear;
      logic               kill;
      logic [QFILL_W-1:0] scan;
      logic [ID_W-1:0]    wr_id;
      logic [CNT_W-1:0]   wr_permits;
   } qcmd_type;

   typedef struct packed {
      logic [QFILL_W-1:0] fill;
      logic [ID_W-1:0]    rd_id;
      logic [CNT_W-1:0]   rd_permits;
      logic               rd_alive;
   } qstat_type;

   // Adds an offset of at most QUEUE_DEPTH to a queue pointer, modulo the depth.
   function automatic logic [QPTR_W-1:0] qwrap(input logic [QPTR_W-1:0] ptr,
                                                input logic [QFILL_W-1:0] off);
      logic [QSUM_W-1:0] sum;
      sum = QSUM_W'(ptr) + QSUM_W'(off);
      if (sum >= QSUM_W'(QUEUE_DEPTH)) begin
         sum = sum - QSUM_W'(QUEUE_DEPTH);
      end
      return sum[QPTR_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fffs_alu.sv =====
`default_nettype none
// Shared adder of the semaphore: saturating add and subtract with borrow.
// Depends on fffs_pkg for the request and result structs.
module fffs_alu (
   input  fffs_pkg::alu_req_type alu_req,
   output fffs_pkg::alu_res_type alu_res
);
   import fffs_pkg::*;

   logic [CNT_W:0]   sum;
   logic [CNT_W-1:0] b_opnd;
   logic             is_sub;

   assign is_sub = (alu_req.op == ALU_SUB);
   assign b_opnd = is_sub ? ~alu_req.b : alu_req.b;
   assign sum    = {1'b0, alu_req.a} + {1'b0, b_opnd} + (CNT_W + 1)'(is_sub);

   always_comb begin
      alu_res.borrow = is_sub && !sum[CNT_W];
      if (!is_sub && sum[CNT_W]) begin
         alu_res.value = '1;
      end else begin
         alu_res.value = sum[CNT_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/fffs_queue.sv =====
`default_nettype none
// Circular waiter queue: requester, permits and live flag per entry.
// Depends on fffs_pkg for sizing, the pointer wrap function and the structs.
module fffs_queue (
   input  logic                clock,
   input  logic                reset,
   input  fffs_pkg::qcmd_type  qcmd,
   output fffs_pkg::qstat_type qstat
);
   import fffs_pkg::*;

   logic [ID_W-1:0]    rid_mem [QUEUE_DEPTH];
   logic [CNT_W-1:0]   rpm_mem [QUEUE_DEPTH];
   logic               alive_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  head_ff;
   logic [QPTR_W-1:0]  head_in;
   logic [QFILL_W-1:0] fill_ff;
   logic [QFILL_W-1:0] fill_in;
   logic [QPTR_W-1:0]  tail;
   logic [QPTR_W-1:0]  rd_slot;
   logic [QPTR_W-1:0]  alive_slot;

   assign tail       = qwrap(head_ff, fill_ff);
   assign rd_slot    = qwrap(head_ff, qcmd.scan);
   assign alive_slot = qcmd.push ? tail : rd_slot;

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (qcmd.head_clear) begin
         head_in = '0;
      end else if (qcmd.pop) begin
         head_in = qwrap(head_ff, QFILL_W'(1));
         fill_in = fill_ff - QFILL_W'(1);
      end else if (qcmd.push) begin
         fill_in = fill_ff + QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (qcmd.push) begin
         rid_mem[tail] <= qcmd.wr_id;
         rpm_mem[tail] <= qcmd.wr_permits;
      end
      if (qcmd.push || qcmd.kill) begin
         alive_mem[alive_slot] <= qcmd.push;
      end
   end

   assign qstat.fill       = fill_ff;
   assign qstat.rd_id      = rid_mem[rd_slot];
   assign qstat.rd_permits = rpm_mem[rd_slot];
   assign qstat.rd_alive   = alive_mem[rd_slot];

endmodule
`default_nettype wire

// ===== hw/rtl/fffs_ctrl.sv =====
`default_nettype none
// Sequencer of the semaphore: free permit count, operation decode, queue walk
// and result register. Depends on fffs_pkg; drives fffs_queue and fffs_alu.
module fffs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic [fffs_pkg::ID_W-1:0]  req_requester_id,
   input  logic [fffs_pkg::CNT_W-1:0] req_permit_count,
   input  logic                     csr_we,
   input  logic [fffs_pkg::CNT_W-1:0] csr_wdata,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_outcome,
   output logic [fffs_pkg::ID_W-1:0]  rsp_granted_id,
   output logic [fffs_pkg::CNT_W-1:0] rsp_granted_permits,
   output logic                     rsp_last,
   output fffs_pkg::qcmd_type       qcmd,
   input  fffs_pkg::qstat_type      qstat,
   output fffs_pkg::alu_req_type    alu_req,
   input  fffs_pkg::alu_res_type    alu_res
);
   import fffs_pkg::*;

   state_type          state_ff;
   state_type          state_in;
   func_type           op_ff;
   logic [ID_W-1:0]    id_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   free_ff;
   logic [CNT_W-1:0]   free_in;
   logic               free_load;
   logic               pend_valid_ff;
   logic [ID_W-1:0]    pend_id_ff;
   logic [CNT_W-1:0]   pend_permits_ff;
   logic               pend_load;
   logic               pend_clear;
   logic [GRANT_W-1:0] grants_ff;
   logic               grant_inc;
   logic [QFILL_W-1:0] scan_ff;
   logic               scan_inc;
   logic               rsp_valid_ff;
   outcome_type        rsp_outcome_ff;
   outcome_type        rsp_outcome_in;
   logic [ID_W-1:0]    rsp_id_ff;
   logic [ID_W-1:0]    rsp_id_in;
   logic [CNT_W-1:0]   rsp_permits_ff;
   logic [CNT_W-1:0]   rsp_permits_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;
   logic               rsp_load;
   logic               accept;
   logic               out_free;
   logic               queue_empty;
   logic               grant_cap;
   logic               walk_done;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign queue_empty = (qstat.fill == '0);
   assign grant_cap   = (grants_ff == GRANT_W'(MAX_RESULTS));
   assign walk_done   = queue_empty || grant_cap || (qstat.rd_alive && alu_res.borrow);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (func_type'(req_func))
                  FN_TRY, FN_ACQ: state_in = ST_ACQ;
                  FN_REL:         state_in = ST_ADD;
                  default:        state_in = ST_CANCEL;
               endcase
            end
         end
         ST_ACQ: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_ADD: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = pend_valid_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CANCEL: begin
            if (scan_ff == qstat.fill) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      alu_req.op      = ALU_SUB;
      alu_req.a       = free_ff;
      alu_req.b       = cnt_ff;
      qcmd            = '0;
      qcmd.scan       = scan_ff;
      qcmd.wr_id      = id_ff;
      qcmd.wr_permits = cnt_ff;
      rsp_load        = 1'b0;
      rsp_outcome_in  = OUT_ACQUIRED;
      rsp_id_in       = id_ff;
      rsp_permits_in  = '0;
      rsp_last_in     = 1'b1;
      free_load       = 1'b0;
      free_in         = alu_res.value;
      pend_load       = 1'b0;
      pend_clear      = 1'b0;
      grant_inc       = 1'b0;
      scan_inc        = 1'b0;
      case (state_ff)
         ST_ACQ: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (queue_empty && !alu_res.borrow) begin
                  free_load      = 1'b1;
                  rsp_permits_in = cnt_ff;
               end else if (op_ff == FN_TRY) begin
                  rsp_outcome_in = OUT_BUSY;
               end else if (qstat.fill == QFILL_W'(QUEUE_DEPTH)) begin
                  rsp_outcome_in = OUT_FULL;
               end else begin
                  rsp_outcome_in = OUT_QUEUED;
                  qcmd.push      = 1'b1;
               end
            end
         end
         ST_ADD: begin
            alu_req.op = ALU_ADD_SAT;
            free_load  = 1'b1;
         end
         ST_WALK: begin
            alu_req.b = qstat.rd_permits;
            if (queue_empty) begin
               qcmd.head_clear = 1'b1;
            end else if (!grant_cap) begin
               if (!qstat.rd_alive) begin
                  qcmd.pop = 1'b1;
               end else if (!alu_res.borrow && (!pend_valid_ff || out_free)) begin
                  free_load      = 1'b1;
                  qcmd.pop       = 1'b1;
                  pend_load      = 1'b1;
                  grant_inc      = 1'b1;
                  rsp_load       = pend_valid_ff;
                  rsp_outcome_in = OUT_GRANTED;
                  rsp_id_in      = pend_id_ff;
                  rsp_permits_in = pend_permits_ff;
                  rsp_last_in    = 1'b0;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_outcome_in = OUT_GRANTED;
               rsp_id_in      = pend_id_ff;
               rsp_permits_in = pend_permits_ff;
               pend_clear     = 1'b1;
            end
         end
         ST_CANCEL: begin
            if (scan_ff != qstat.fill) begin
               scan_inc  = 1'b1;
               qcmd.kill = (qstat.rd_id == id_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_ff       <= CAPACITY_RESET;
         pend_valid_ff <= 1'b0;
         grants_ff     <= '0;
         scan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (free_load) begin
            free_ff <= free_in;
         end
         if (csr_we) begin
            free_ff <= csr_wdata;
         end
         if (pend_load) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_clear) begin
            pend_valid_ff <= 1'b0;
         end
         if (accept) begin
            grants_ff <= '0;
            scan_ff   <= '0;
         end else begin
            if (grant_inc) begin
               grants_ff <= grants_ff + GRANT_W'(1);
            end
            if (scan_inc) begin
               scan_ff <= scan_ff + QFILL_W'(1);
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= func_type'(req_func);
         id_ff  <= req_requester_id;
         cnt_ff <= req_permit_count;
      end
      if (pend_load) begin
         pend_id_ff      <= qstat.rd_id;
         pend_permits_ff <= qstat.rd_permits;
      end
      if (rsp_load) begin
         rsp_outcome_ff <= rsp_outcome_in;
         rsp_id_ff      <= rsp_id_in;
         rsp_permits_ff <= rsp_permits_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = rsp_outcome_ff;
   assign rsp_granted_id      = rsp_id_ff;
   assign rsp_granted_permits = rsp_permits_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/fifo_fair_counting_semaphore.sv =====
`default_nettype none
// Top level of the fair FIFO counting semaphore.
// Depends on fffs_pkg and instantiates fffs_ctrl, fffs_queue and fffs_alu.
//
//   Port group   Direction  Beat contents
//   req_         in         func, requester_id, permit_count
//   rsp_         out        outcome, granted_id, granted_permits, last
//   csr_         in         capacity, loaded into the free permit count
//
// Try and acquire go from idle to the compare state, which loads the result register once free.
// Release adds the permits in the add state, then walks the queue entry by entry (at most
// QUEUE_DEPTH entries), and goes to the flush state when a grant is left to send.
// Cancel scans each queued entry in the cancel state.
// Reset clears the queue and loads the free count with one permit.
// A stalled result holds the walk until the result register frees up.
module fifo_fair_counting_semaphore (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_func,
   input  logic [fffs_pkg::ID_W-1:0]  req_requester_id,
   input  logic [fffs_pkg::CNT_W-1:0] req_permit_count,
   input  logic                       csr_we,
   input  logic [fffs_pkg::CNT_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_outcome,
   output logic [fffs_pkg::ID_W-1:0]  rsp_granted_id,
   output logic [fffs_pkg::CNT_W-1:0] rsp_granted_permits,
   output logic                       rsp_last
);
   import fffs_pkg::*;

   qcmd_type    qcmd;
   qstat_type   qstat;
   alu_req_type alu_req;
   alu_res_type alu_res;

   fffs_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_requester_id    (req_requester_id),
      .req_permit_count    (req_permit_count),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_outcome         (rsp_outcome),
      .rsp_granted_id      (rsp_granted_id),
      .rsp_granted_permits (rsp_granted_permits),
      .rsp_last            (rsp_last),
      .qcmd                (qcmd),
      .qstat               (qstat),
      .alu_req             (alu_req),
      .alu_res             (alu_res)
   );

   fffs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qcmd  (qcmd),
      .qstat (qstat)
   );

   fffs_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/fffs_checker.sv =====
`default_nettype none
// Port-level checks for the fair FIFO counting semaphore, bound to its top.
// Depends on fffs_pkg for widths and outcome codes.
module fffs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [2:0]                 rsp_outcome,
   input logic [fffs_pkg::ID_W-1:0]  rsp_granted_id,
   input logic [fffs_pkg::CNT_W-1:0] rsp_granted_permits,
   input logic                       rsp_last
);
   import fffs_pkg::*;

   a_reset_clears_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("new beat taken while a request is in progress");

   a_rsp_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_outcome)
         && $stable(rsp_granted_id) && $stable(rsp_granted_permits) && $stable(rsp_last)))
      else $error("stalled result beat changed");

   a_single_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome != OUT_GRANTED) |-> rsp_last)
      else $error("direct answer not marked last");

   a_refusal_no_permits : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == OUT_QUEUED || rsp_outcome == OUT_BUSY
         || rsp_outcome == OUT_FULL)) |-> (rsp_granted_permits == '0))
      else $error("permits reported on a refused or queued request");

endmodule

bind fifo_fair_counting_semaphore fffs_checker u_checker (.*);
`default_nettype wire
